// ----- design/swmm_pkg.sv -----
// ----------------------------------------------------------------------------
// swmm_pkg
// Shared types and constants for the sliding window min/max/mean core.
// ----------------------------------------------------------------------------
package swmm_pkg;

   // window length register
   localparam int LEN_W = 5;
   localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(12);

   // controller to datapath
   typedef struct packed {
      logic clear;     // length write, history dropped
      logic accept;    // latch item, read oldest slot
      logic update;    // evict, store, update total and count
      logic scan;      // walk the ring for min and max
      logic div_load;  // start mean division
      logic div_step;  // one quotient bit
      logic out_load;  // load result register
   } swmm_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_done;
      logic div_last;
   } swmm_status_type;

endpackage

// ----- design/sliding_window_min_max_mean_core.sv -----
// ----------------------------------------------------------------------------
// sliding_window_min_max_mean_core
// Running max, min, truncated mean and count over the most recent samples.
// ----------------------------------------------------------------------------
// Each accepted sample enters a ring of MAX_WINDOW entries, evicting the
// oldest one once the programmed window length is reached, and produces one
// result: window max, min, truncated mean and samples held. The ring memory
// is scanned one entry per cycle on its single read port and the mean comes
// from a restoring divider that yields one quotient bit per cycle. A new
// sample is taken as soon as the previous result sits in the output
// register. Writing the window length (0 acts as 1, values above MAX_WINDOW
// saturate) clears the history; the write is taken only between items.
module sliding_window_min_max_mean_core #(
   parameter int MAX_WINDOW  = 16,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [SAMPLE_BITS-1:0]              req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [SAMPLE_BITS-1:0]              rsp_window_max,
   output logic [SAMPLE_BITS-1:0]              rsp_window_min,
   output logic [SAMPLE_BITS-1:0]              rsp_window_mean,
   output logic [$clog2(MAX_WINDOW + 1)-1:0]   rsp_samples_held,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [swmm_pkg::LEN_W-1:0]          csr_window_length
);

   localparam int CNT_W = $clog2(MAX_WINDOW + 1);

   swmm_pkg::swmm_cmd_type    cmd;
   swmm_pkg::swmm_status_type status;

   swmm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .cmd       (cmd),
      .status    (status)
   );

   swmm_datapath #(
      .MAX_WINDOW  (MAX_WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS),
      .CNT_W       (CNT_W)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_window_length (csr_window_length),
      .req_sample        (req_sample),
      .rsp_window_max    (rsp_window_max),
      .rsp_window_min    (rsp_window_min),
      .rsp_window_mean   (rsp_window_mean),
      .rsp_samples_held  (rsp_samples_held)
   );

   // a delivered window is never empty and never deeper than the ring
   a_held_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_samples_held != '0) &&
                    (32'(rsp_samples_held) <= 32'(MAX_WINDOW)))
      else $error("samples held out of range");

   // mean lies between min and max
   a_mean_bounds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_window_min <= rsp_window_mean) &&
                    (rsp_window_mean <= rsp_window_max))
      else $error("mean outside min/max");

   // busy after an item is taken, so no second item enters mid-flight
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall && !csr_ready)
      else $error("input open while item in flight");

endmodule

// ----- design/swmm_datapath.sv -----
// ----------------------------------------------------------------------------
// swmm_datapath
// Sample ring, running total, min/max scan and serial divider for the mean.
// ----------------------------------------------------------------------------
module swmm_datapath #(
   parameter int MAX_WINDOW  = 16,
   parameter int SAMPLE_BITS = 16,
   parameter int CNT_W       = $clog2(MAX_WINDOW + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  swmm_pkg::swmm_cmd_type       cmd,
   output swmm_pkg::swmm_status_type    status,
   input  logic [swmm_pkg::LEN_W-1:0]   csr_window_length,
   input  logic [SAMPLE_BITS-1:0]       req_sample,
   output logic [SAMPLE_BITS-1:0]       rsp_window_max,
   output logic [SAMPLE_BITS-1:0]       rsp_window_min,
   output logic [SAMPLE_BITS-1:0]       rsp_window_mean,
   output logic [CNT_W-1:0]             rsp_samples_held
);

   localparam int PTR_W  = $clog2(MAX_WINDOW);
   localparam int TOT_W  = SAMPLE_BITS + $clog2(MAX_WINDOW);
   localparam int STEP_W = $clog2(TOT_W + 1);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(MAX_WINDOW - 1);
   localparam logic [CNT_W:0]   MAX_EXT   = (CNT_W + 1)'(MAX_WINDOW);

   logic [SAMPLE_BITS-1:0] ring_mem [MAX_WINDOW];
   logic [SAMPLE_BITS-1:0] rd_data_ff;
   logic [PTR_W-1:0]       rd_addr;

   logic [swmm_pkg::LEN_W-1:0] length_ff;
   logic [CNT_W-1:0]       len_eff;
   logic [PTR_W-1:0]       slot_ff, slot_in;
   logic [CNT_W-1:0]       fill_ff, fill_in;
   logic [TOT_W-1:0]       total_ff, total_in;
   logic [SAMPLE_BITS-1:0] sample_ff;
   logic                   full;

   logic [PTR_W-1:0]       ptr_ff, ptr_in;
   logic [CNT_W-1:0]       left_ff, left_in;
   logic                   rvalid_ff, rvalid_in;
   logic [SAMPLE_BITS-1:0] hi_ff, hi_in, lo_ff, lo_in;
   logic [PTR_W-1:0]       oldest;
   logic [CNT_W:0]         slot_ext, fill_ext;

   logic [TOT_W-1:0]       dq_ff, dq_in;
   logic [CNT_W-1:0]       rem_ff, rem_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic [CNT_W:0]         trial;
   logic [CNT_W:0]         divisor;

   logic [SAMPLE_BITS-1:0] max_ff, min_ff, mean_ff;
   logic [CNT_W-1:0]       held_ff;

   // length zero acts as one, above the ring depth it saturates
   always_comb begin
      if (length_ff == '0) begin
         len_eff = CNT_W'(1);
      end else if (32'(length_ff) > 32'(MAX_WINDOW)) begin
         len_eff = CNT_W'(MAX_WINDOW);
      end else begin
         len_eff = CNT_W'(length_ff);
      end
   end

   assign full     = (fill_ff >= len_eff);
   assign slot_ext = (CNT_W + 1)'(slot_ff);
   assign fill_ext = (CNT_W + 1)'(fill_ff);

   always_comb begin
      if (slot_ext >= fill_ext) begin
         oldest = PTR_W'(slot_ext - fill_ext);
      end else begin
         oldest = PTR_W'(slot_ext + MAX_EXT - fill_ext);
      end
   end

   assign rd_addr = cmd.scan ? ptr_ff : oldest;

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         ring_mem[slot_ff] <= sample_ff;
      end
      rd_data_ff <= ring_mem[rd_addr];
   end

   // history update and scan
   always_comb begin
      slot_in   = slot_ff;
      fill_in   = fill_ff;
      total_in  = total_ff;
      ptr_in    = ptr_ff;
      left_in   = left_ff;
      rvalid_in = 1'b0;
      hi_in     = hi_ff;
      lo_in     = lo_ff;
      if (cmd.clear) begin
         slot_in  = '0;
         fill_in  = '0;
         total_in = '0;
      end else if (cmd.update) begin
         total_in = total_ff - (full ? TOT_W'(rd_data_ff) : '0) + TOT_W'(sample_ff);
         fill_in  = full ? len_eff : fill_ff + 1'b1;
         slot_in  = (slot_ff == LAST_SLOT) ? '0 : slot_ff + 1'b1;
         ptr_in   = (slot_ff == '0) ? LAST_SLOT : slot_ff - 1'b1;
         left_in  = (full ? len_eff : fill_ff + 1'b1) - 1'b1;
         hi_in    = sample_ff;
         lo_in    = sample_ff;
      end else if (cmd.scan) begin
         if (left_ff != '0) begin
            rvalid_in = 1'b1;
            left_in   = left_ff - 1'b1;
            ptr_in    = (ptr_ff == '0) ? LAST_SLOT : ptr_ff - 1'b1;
         end
         if (rvalid_ff) begin
            if (rd_data_ff > hi_ff) begin
               hi_in = rd_data_ff;
            end
            if (rd_data_ff < lo_ff) begin
               lo_in = rd_data_ff;
            end
         end
      end
   end

   // restoring divider, one quotient bit per cycle
   assign divisor = (CNT_W + 1)'(fill_ff);
   assign trial   = {rem_ff, dq_ff[TOT_W-1]};

   always_comb begin
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      if (cmd.div_load) begin
         dq_in   = total_ff;
         rem_in  = '0;
         step_in = STEP_W'(TOT_W);
      end else if (cmd.div_step) begin
         step_in = step_ff - 1'b1;
         if (trial >= divisor) begin
            rem_in = CNT_W'(trial - divisor);
            dq_in  = {dq_ff[TOT_W-2:0], 1'b1};
         end else begin
            rem_in = CNT_W'(trial);
            dq_in  = {dq_ff[TOT_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= swmm_pkg::LEN_RESET;
         slot_ff   <= '0;
         fill_ff   <= '0;
         total_ff  <= '0;
         left_ff   <= '0;
         rvalid_ff <= 1'b0;
         step_ff   <= '0;
      end else begin
         if (cmd.clear) begin
            length_ff <= csr_window_length;
         end
         slot_ff   <= slot_in;
         fill_ff   <= fill_in;
         total_ff  <= total_in;
         left_ff   <= left_in;
         rvalid_ff <= rvalid_in;
         step_ff   <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sample_ff <= req_sample;
      end
      ptr_ff <= ptr_in;
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      if (cmd.out_load) begin
         max_ff  <= hi_ff;
         min_ff  <= lo_ff;
         mean_ff <= dq_ff[SAMPLE_BITS-1:0];
         held_ff <= fill_ff;
      end
   end

   assign status.scan_done = (left_ff == '0) && !rvalid_ff;
   assign status.div_last  = (step_ff == STEP_W'(1));

   assign rsp_window_max   = max_ff;
   assign rsp_window_min   = min_ff;
   assign rsp_window_mean  = mean_ff;
   assign rsp_samples_held = held_ff;

endmodule

// ----- design/swmm_ctrl.sv -----
// ----------------------------------------------------------------------------
// swmm_ctrl
// Sequencer for one item: update, scan, divide, then hand off the result.
// ----------------------------------------------------------------------------
module swmm_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   output swmm_pkg::swmm_cmd_type      cmd,
   input  swmm_pkg::swmm_status_type   status
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_SCAN,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      idle;
   logic      out_free;

   assign idle      = (state_ff == ST_IDLE) && !reset;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = idle;
   // a length write wins over an item in the same cycle
   assign req_stall = !idle || csr_valid;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            cmd.clear  = csr_valid;
            cmd.accept = req_valid && !csr_valid;
            if (req_valid && !csr_valid) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_done) begin
               cmd.div_load = 1'b1;
               state_in     = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- tb/sv/tb_sliding_window_min_max_mean_core.sv -----
// ----------------------------------------------------------------------------
// tb_sliding_window_min_max_mean_core
// Self-checking regression for the sliding window min/max/mean core.
// ----------------------------------------------------------------------------
// Samples go in over the req_ channel and window statistics come back over
// rsp_. A behavioral copy of the window is advanced on every accepted sample
// and the predicted max, min, mean and count are queued for the response
// monitor. The window length register is reprogrammed only after every
// queued result has come back. Both sides idle and stall at random.
module tb_sliding_window_min_max_mean_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RING_DEPTH = 16;
   localparam int SAMPLE_W   = 16;
   localparam int HELD_W     = $clog2(RING_DEPTH + 1);
   localparam int LEN_W      = swmm_pkg::LEN_W;

   typedef struct packed {
      logic [SAMPLE_W-1:0] hi;
      logic [SAMPLE_W-1:0] lo;
      logic [SAMPLE_W-1:0] mean;
      logic [HELD_W-1:0]   held;
   } window_stats_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [SAMPLE_W-1:0] req_sample;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [SAMPLE_W-1:0] rsp_window_max;
   logic [SAMPLE_W-1:0] rsp_window_min;
   logic [SAMPLE_W-1:0] rsp_window_mean;
   logic [HELD_W-1:0]   rsp_samples_held;
   logic                csr_valid;
   logic                csr_ready;
   logic [LEN_W-1:0]    csr_window_length;

   // shadow window state
   logic [LEN_W-1:0]    shadow_length;
   logic [SAMPLE_W-1:0] shadow_ring [RING_DEPTH];
   int unsigned         shadow_slot;
   int unsigned         shadow_held;
   int unsigned         shadow_total;

   window_stats_type expected_stats [$];
   int unsigned   mismatch_count;
   int unsigned   hold_cycles;
   int unsigned   stall_left;
   bit            req_idling;
   bit            rsp_idling;
   logic [SAMPLE_W-1:0] last_sample;

   sliding_window_min_max_mean_core #(
      .MAX_WINDOW  (RING_DEPTH),
      .SAMPLE_BITS (SAMPLE_W)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sample        (req_sample),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_window_max    (rsp_window_max),
      .rsp_window_min    (rsp_window_min),
      .rsp_window_mean   (rsp_window_mean),
      .rsp_samples_held  (rsp_samples_held),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_window_length (csr_window_length)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   function automatic void clear_window();
      shadow_slot  = 0;
      shadow_held  = 0;
      shadow_total = 0;
   endfunction

   // push one sample into the shadow window and return the statistics
   function automatic window_stats_type advance_window(input logic [SAMPLE_W-1:0] value);
      window_stats_type stats;
      int unsigned   span;
      int unsigned   idx;
      span = (shadow_length == 0) ? 1 :
             (shadow_length > RING_DEPTH) ? RING_DEPTH : shadow_length;
      if (shadow_held >= span) begin
         // full: evict the oldest entry
         idx = (shadow_slot + RING_DEPTH - shadow_held) % RING_DEPTH;
         shadow_total -= shadow_ring[idx];
         shadow_held = span - 1;
      end
      shadow_ring[shadow_slot] = value;
      shadow_total += value;
      shadow_held++;
      shadow_slot = (shadow_slot + 1) % RING_DEPTH;
      stats.hi = value;
      stats.lo = value;
      for (int k = 1; k < shadow_held; k++) begin
         idx = (shadow_slot + RING_DEPTH - 1 - k) % RING_DEPTH;
         if (shadow_ring[idx] > stats.hi) stats.hi = shadow_ring[idx];
         if (shadow_ring[idx] < stats.lo) stats.lo = shadow_ring[idx];
      end
      stats.mean = SAMPLE_W'(shadow_total / shadow_held);
      stats.held = HELD_W'(shadow_held);
      return stats;
   endfunction

   // mostly short gaps, a few long ones
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 12);
      return $urandom_range(30, 80);
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0: last_sample = '0;
         1: last_sample = '1;
         2: last_sample = SAMPLE_W'($urandom_range(0, 15));
         3: last_sample = SAMPLE_W'(16'hfff0 + $urandom_range(0, 15));
         4: last_sample = last_sample + SAMPLE_W'($urandom_range(0, 40));  // rising run
         5: last_sample = last_sample - SAMPLE_W'($urandom_range(0, 40));  // falling run
         default: last_sample = SAMPLE_W'($urandom);
      endcase
      return last_sample;
   endfunction

   task automatic send_sample(input logic [SAMPLE_W-1:0] value);
      int unsigned gap;
      req_valid  <= 1'b1;
      req_sample <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_stats.push_back(advance_window(value));
      gap = req_idling ? pick_gap() : 0;
      if (gap != 0) begin
         req_valid  <= 1'b0;
         req_sample <= SAMPLE_W'($urandom);
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (expected_stats.size() != 0) @(posedge clock);
   endtask

   task automatic write_window_length(input logic [LEN_W-1:0] length);
      wait_for_results();
      csr_valid         <= 1'b1;
      csr_window_length <= length;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      shadow_length = length;
      clear_window();
   endtask

   // receiver: long hold-offs first, then random stall runs
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_cycles != 0) begin
         rsp_stall <= 1'b1;
         hold_cycles--;
      end else if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (rsp_idling && $urandom_range(0, 3) == 0) begin
         stall_left = pick_gap();
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic check_field(input string field, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("mismatch on %s: expected %0d, got %0d at %0t", field, want, got,
                     $realtime);
      end
   endtask

   // response monitor
   always @(posedge clock) begin
      window_stats_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_stats.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected item on rsp at %0t", $realtime);
         end else begin
            want = expected_stats.pop_front();
            check_field("window_max", want.hi, rsp_window_max);
            check_field("window_min", want.lo, rsp_window_min);
            check_field("window_mean", want.mean, rsp_window_mean);
            check_field("samples_held", want.held, rsp_samples_held);
         end
      end
   end

   // reset length, extremes, and the first eviction
   task automatic test_reset_window();
      logic [SAMPLE_W-1:0] values [13];
      values = '{16'h0000, 16'hffff, 16'h0001, 16'hfffe, 16'h8000, 16'h7fff, 16'haaaa,
                 16'h5555, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'h0000};
      foreach (values[i]) send_sample(values[i]);
   endtask

   // zero length acts as a window of one
   task automatic test_zero_length();
      write_window_length('0);
      send_sample(16'hffff);
      send_sample(16'h0000);
   endtask

   // rewriting the same length still drops the history
   task automatic test_same_length_write();
      write_window_length(5'd5);
      send_sample(16'h1234);
      send_sample(16'hffff);
      send_sample(16'h0007);
      write_window_length(5'd5);
      send_sample(16'h0100);
      send_sample(16'h0300);
   endtask

   // receiver holds off long enough for the core to stall its input
   task automatic test_output_backpressure();
      req_idling = 1'b0;
      rsp_idling = 1'b0;
      write_window_length(5'd16);
      hold_cycles = 300;
      repeat (20) send_sample(pick_sample());
      wait_for_results();
      req_idling = 1'b1;
      rsp_idling = 1'b1;
      repeat (20) send_sample(pick_sample());
   endtask

   task automatic test_random_windows();
      logic [LEN_W-1:0] lengths [10];
      lengths = '{5'd1, 5'd16, 5'd31, 5'd17, 5'd2, 5'd0, 5'd7,
                  LEN_W'($urandom_range(0, 31)), LEN_W'($urandom_range(0, 31)),
                  LEN_W'($urandom_range(0, 31))};
      foreach (lengths[i]) begin
         write_window_length(lengths[i]);
         // every third phase runs without any idling
         req_idling = (i % 3) != 0;
         rsp_idling = (i % 3) != 0;
         repeat (72) send_sample(pick_sample());
      end
   endtask

   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_sample        = '0;
      csr_valid         = 1'b0;
      csr_window_length = '0;
      mismatch_count    = 0;
      hold_cycles       = 0;
      stall_left        = 0;
      last_sample       = '0;
      req_idling        = 1'b1;
      rsp_idling        = 1'b1;
      shadow_length     = swmm_pkg::LEN_RESET;
      clear_window();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_window();
      test_zero_length();
      test_same_length_write();
      test_output_backpressure();
      test_random_windows();

      wait_for_results();
      repeat (60) @(posedge clock);
      if (mismatch_count == 0 && expected_stats.size() == 0)
         $display("sliding_window_min_max_mean_core regression: pass");
      else
         $display("sliding_window_min_max_mean_core regression: fail");
      $finish;
   end

   initial begin
      #4_000_000;
      $display("sliding_window_min_max_mean_core regression: fail");
      $finish;
   end

endmodule
